[design/background_subtracted_centroid_assert.svh]
// Assertion macros used by the checker of the centroid block.
`ifndef BACKGROUND_SUBTRACTED_CENTROID_ASSERT_SVH
`define BACKGROUND_SUBTRACTED_CENTROID_ASSERT_SVH

// Implication checked in the same cycle, masked while reset is low.
`define BSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent, active during reset too.
`define BSC_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/bsc_pkg.sv]
// Shared types and constants of the background subtracted centroid block.
package bsc_pkg;

    localparam int POSITION_BITS_DEF = 12;
    localparam int SAMPLE_W          = 32;
    localparam int CFG_W             = 32;
    localparam int CFG_IDX_W         = 2;
    localparam int WEIGHTED_W        = 64;
    localparam int WEIGHT_W          = 48;
    localparam int RESULT_W          = 32;
    localparam int QUEUE_DEPTH       = 2;
    localparam int DIV_STEPS         = WEIGHTED_W + 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_INTERCEPT = CFG_IDX_W'(1);

    // Finished accumulator pair of one profile.
    typedef struct packed {
        logic [WEIGHTED_W-1:0] weighted_sum;
        logic [WEIGHT_W-1:0]   weight_sum;
    } t_profile;

endpackage

[design/bsc_front.sv]
// Front part: background removal pipeline and saturating accumulators.
module bsc_front #(
    parameter int POSITION_BITS = bsc_pkg::POSITION_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic [POSITION_BITS-1:0]         i_pos,
    input  logic [bsc_pkg::SAMPLE_W-1:0]     i_sample,
    input  logic                             i_last,
    input  logic [bsc_pkg::CFG_W-1:0]        i_slope,
    input  logic [bsc_pkg::CFG_W-1:0]        i_intercept,
    output logic                             o_push,
    output bsc_pkg::t_profile                o_profile
);

    localparam int PW      = POSITION_BITS;
    localparam int BGP_W   = bsc_pkg::CFG_W + PW + 1;
    localparam int BG_W    = BGP_W - 8;
    localparam int RESID_W = ((BG_W > bsc_pkg::SAMPLE_W + 1) ? BG_W : bsc_pkg::SAMPLE_W + 1) + 1;
    localparam int WPROD_W = RESID_W + PW + 1;
    localparam int WD_W    = bsc_pkg::WEIGHTED_W;
    localparam int WT_W    = bsc_pkg::WEIGHT_W;

    // stage 1: background product
    logic                           r1_v, r1_last;
    logic [PW-1:0]                  r1_pos;
    logic signed [bsc_pkg::SAMPLE_W-1:0] r1_sample;
    logic signed [BGP_W-1:0]        r1_bgprod;
    // stage 2: residual
    logic                           r2_v, r2_last;
    logic [PW-1:0]                  r2_pos;
    logic signed [RESID_W-1:0]      r2_resid;
    // stage 3: residual times position
    logic                           r3_v, r3_last;
    logic signed [RESID_W-1:0]      r3_resid;
    logic signed [WPROD_W-1:0]      r3_wprod;
    // accumulators
    logic signed [WD_W-1:0]         r_weighted;
    logic signed [WT_W-1:0]         r_weight;

    logic signed [BGP_W-1:0]        w_bgr;
    logic signed [BG_W-1:0]         w_bg;
    logic signed [RESID_W-1:0]      w_resid;
    logic signed [WT_W:0]           w_wt_sum;
    logic signed [WD_W:0]           w_wd_sum;
    logic signed [WT_W-1:0]         n_weight;
    logic signed [WD_W-1:0]         n_weighted;

    // round to nearest, ties up: add half an LSB, then floor shift
    assign w_bgr   = r1_bgprod + $signed(BGP_W'(128));
    assign w_bg    = BG_W'(w_bgr >>> 8);
    assign w_resid = RESID_W'(r1_sample) - RESID_W'($signed(i_intercept)) - RESID_W'(w_bg);

    assign w_wt_sum = (WT_W + 1)'(r_weight) + (WT_W + 1)'(r3_resid);
    assign w_wd_sum = (WD_W + 1)'(r_weighted) + (WD_W + 1)'(r3_wprod);

    always_comb begin
        if (w_wt_sum[WT_W] != w_wt_sum[WT_W-1]) begin
            n_weight = w_wt_sum[WT_W] ? {1'b1, {(WT_W - 1){1'b0}}} : {1'b0, {(WT_W - 1){1'b1}}};
        end else begin
            n_weight = w_wt_sum[WT_W-1:0];
        end
        if (w_wd_sum[WD_W] != w_wd_sum[WD_W-1]) begin
            n_weighted = w_wd_sum[WD_W] ? {1'b1, {(WD_W - 1){1'b0}}} : {1'b0, {(WD_W - 1){1'b1}}};
        end else begin
            n_weighted = w_wd_sum[WD_W-1:0];
        end
    end

    assign o_push                 = r3_v & r3_last;
    assign o_profile.weighted_sum = n_weighted;
    assign o_profile.weight_sum   = n_weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v       <= 1'b0;
            r2_v       <= 1'b0;
            r3_v       <= 1'b0;
            r_weighted <= '0;
            r_weight   <= '0;
        end else begin
            r1_v <= i_accept;
            r2_v <= r1_v;
            r3_v <= r2_v;
            if (r3_v) begin
                // clear after the last sample of a profile
                r_weighted <= r3_last ? '0 : n_weighted;
                r_weight   <= r3_last ? '0 : n_weight;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r1_pos    <= i_pos;
        r1_sample <= $signed(i_sample);
        r1_last   <= i_last;
        r1_bgprod <= $signed(i_slope) * $signed({1'b0, i_pos});
        r2_pos    <= r1_pos;
        r2_last   <= r1_last;
        r2_resid  <= w_resid;
        r3_last   <= r2_last;
        r3_resid  <= r2_resid;
        r3_wprod  <= r2_resid * $signed({1'b0, r2_pos});
    end

endmodule

[design/bsc_queue.sv]
// Short queue of finished profiles between the front and the divider.
module bsc_queue #(
    parameter int DEPTH = bsc_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bsc_pkg::t_profile i_data,
    input  logic              i_pop,
    output logic              o_valid,
    output bsc_pkg::t_profile o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bsc_pkg::t_profile r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[design/bsc_back.sv]
// Back part: bit-serial divider producing the rounded, saturated centroid.
module bsc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  bsc_pkg::t_profile             i_data,
    output logic                          o_pop,
    output logic                          o_strobe,
    output logic [bsc_pkg::RESULT_W-1:0]  o_centroid,
    output logic                          o_zero
);

    localparam int ND_W  = bsc_pkg::WEIGHTED_W;
    localparam int DN_W  = bsc_pkg::WEIGHT_W;
    localparam int Q_W   = bsc_pkg::RESULT_W + 2;
    localparam int CNT_W = $clog2(bsc_pkg::DIV_STEPS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_ROUND
    } t_state;

    t_state            r_state;
    logic [ND_W-1:0]   r_num;
    logic [DN_W-1:0]   r_den, r_rem;
    logic [Q_W-1:0]    r_q;
    logic              r_big, r_neg;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_strobe, r_zero;
    logic [bsc_pkg::RESULT_W-1:0] r_centroid;

    logic [ND_W-1:0]   w_num_mag;
    logic [DN_W-1:0]   w_den_mag;
    logic [DN_W:0]     w_rem_sh;
    logic              w_qbit;
    logic [DN_W-1:0]   n_rem;
    logic [Q_W:0]      w_q_full;
    logic [Q_W:0]      w_qr;
    logic [bsc_pkg::RESULT_W-1:0] w_result;

    assign w_num_mag = i_data.weighted_sum[ND_W-1] ? (~i_data.weighted_sum + 1'b1)
                                                     : i_data.weighted_sum;
    assign w_den_mag = i_data.weight_sum[DN_W-1] ? (~i_data.weight_sum + 1'b1)
                                                   : i_data.weight_sum;

    // one restoring step: bring down the next dividend bit
    assign w_rem_sh = {r_rem, r_num[ND_W-1]};
    assign w_qbit   = (w_rem_sh >= {1'b0, r_den});
    assign n_rem    = w_qbit ? DN_W'(w_rem_sh - {1'b0, r_den}) : w_rem_sh[DN_W-1:0];
    assign w_q_full = {r_q, w_qbit};

    // round half away from zero on magnitude, then saturate by sign
    assign w_qr = (Q_W + 1)'(r_q) + (Q_W + 1)'({r_rem, 1'b0} >= {1'b0, r_den});

    always_comb begin
        if (r_neg) begin
            if (r_big || w_qr > (Q_W + 1)'(33'h0_8000_0000)) begin
                w_result = {1'b1, {(bsc_pkg::RESULT_W - 1){1'b0}}};
            end else begin
                w_result = bsc_pkg::RESULT_W'(~w_qr + 1'b1);
            end
        end else begin
            if (r_big || w_qr > (Q_W + 1)'(33'h0_7FFF_FFFF)) begin
                w_result = {1'b0, {(bsc_pkg::RESULT_W - 1){1'b1}}};
            end else begin
                w_result = w_qr[bsc_pkg::RESULT_W-1:0];
            end
        end
    end

    assign o_pop      = (r_state == S_IDLE) && i_valid;
    assign o_strobe   = r_strobe;
    assign o_centroid = r_centroid;
    assign o_zero     = r_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_data.weight_sum == '0) begin
                            r_strobe   <= 1'b1;
                            r_zero     <= 1'b1;
                            r_centroid <= '0;
                        end else begin
                            r_num   <= w_num_mag;
                            r_den   <= w_den_mag;
                            r_rem   <= '0;
                            r_q     <= '0;
                            r_big   <= 1'b0;
                            r_cnt   <= '0;
                            r_neg   <= i_data.weighted_sum[ND_W-1] ^ i_data.weight_sum[DN_W-1];
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_num <= {r_num[ND_W-2:0], 1'b0};
                    r_rem <= n_rem;
                    r_q   <= w_q_full[Q_W-1:0];
                    // once past 2^32 the quotient only grows: mark saturation
                    r_big <= r_big | (w_q_full > (Q_W + 1)'(33'h1_0000_0000));
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(bsc_pkg::DIV_STEPS - 1)) begin
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_strobe   <= 1'b1;
                    r_zero     <= 1'b0;
                    r_centroid <= w_result;
                    r_state    <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[design/background_subtracted_centroid.sv]
// Top level of the background subtracted weighted centroid block.
//
//  channel   | handshake                      | payload
//  ----------+--------------------------------+--------------------------------------------
//  sample    | i_start high, o_busy low       | i_pixel_position, i_sample_value,
//            |                                | i_last_sample
//  result    | o_result_strobe, one cycle     | o_centroid_position, o_zero_weight
//  config    | i_cfg_valid and o_cfg_ready    | i_cfg_index, i_cfg_data
//
// Samples enter at one beat per cycle while o_busy is low; each goes through a four stage
// removal and accumulation pipeline. A profile ending in a zero weight gets its result
// from the divider's idle state with no division; any other profile is popped, divided
// in the bit-serial divider, one quotient bit per cycle over 80 steps, and rounded.
// o_busy rises while two profiles whose last sample was taken still wait for the
// divider, so the queue never overflows. The result side cannot stall.
// Reset is synchronous: it clears the accumulators, the queue and both registers.
module background_subtracted_centroid #(
    parameter int POSITION_BITS = bsc_pkg::POSITION_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // sample channel
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic [POSITION_BITS-1:0]         i_pixel_position,
    input  logic [bsc_pkg::SAMPLE_W-1:0]     i_sample_value,
    input  logic                             i_last_sample,
    // result channel
    output logic                             o_result_strobe,
    output logic [bsc_pkg::RESULT_W-1:0]     o_centroid_position,
    output logic                             o_zero_weight,
    // configuration channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bsc_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int PEND_W = $clog2(bsc_pkg::QUEUE_DEPTH + 1);

    logic [bsc_pkg::CFG_W-1:0] r_slope, r_intercept;
    logic [PEND_W-1:0]         r_pend;

    logic              w_accept;
    logic              w_push, w_pop, w_q_valid;
    bsc_pkg::t_profile w_push_data, w_head;

    // a beat is taken whenever start meets a free slot for its profile
    assign w_accept    = i_start & ~o_busy;
    assign o_busy      = (r_pend == PEND_W'(bsc_pkg::QUEUE_DEPTH));
    assign o_cfg_ready = 1'b1;

    // Count profiles whose last beat was taken but that the divider has not popped:
    // holds pipeline and queue together under the queue depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + PEND_W'(w_accept & i_last_sample) - PEND_W'(w_pop);
        end
    end

    // Configuration registers; unknown indexes drop the write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slope     <= '0;
            r_intercept <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                bsc_pkg::CFG_SLOPE:     r_slope     <= i_cfg_data;
                bsc_pkg::CFG_INTERCEPT: r_intercept <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bsc_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_pos       (i_pixel_position),
        .i_sample    (i_sample_value),
        .i_last      (i_last_sample),
        .i_slope     (r_slope),
        .i_intercept (r_intercept),
        .o_push      (w_push),
        .o_profile   (w_push_data)
    );

    bsc_queue #(
        .DEPTH (bsc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_head)
    );

    bsc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_q_valid),
        .i_data     (w_head),
        .o_pop      (w_pop),
        .o_strobe   (o_result_strobe),
        .o_centroid (o_centroid_position),
        .o_zero     (o_zero_weight)
    );

endmodule

[design/bsc_checker.sv]
// Port-level checker of the centroid block and its bind.
`include "background_subtracted_centroid_assert.svh"

module bsc_checker #(
    parameter int POSITION_BITS = bsc_pkg::POSITION_BITS_DEF
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_start,
    input logic                             o_busy,
    input logic [POSITION_BITS-1:0]         i_pixel_position,
    input logic [bsc_pkg::SAMPLE_W-1:0]     i_sample_value,
    input logic                             i_last_sample,
    input logic                             o_result_strobe,
    input logic [bsc_pkg::RESULT_W-1:0]     o_centroid_position,
    input logic                             o_zero_weight,
    input logic                             i_cfg_valid,
    input logic                             o_cfg_ready,
    input logic [bsc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input logic [bsc_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int OUT_W = $clog2(bsc_pkg::QUEUE_DEPTH + 2);

    logic [OUT_W-1:0] r_outstanding;
    logic             w_last_beat;

    assign w_last_beat = i_start && !o_busy && i_last_sample;

    // profiles closed by a last beat whose result has not yet appeared
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            r_outstanding <= r_outstanding + OUT_W'(w_last_beat) - OUT_W'(o_result_strobe);
        end
    end

    `BSC_ASSERT_IMP(a_result_has_profile, i_clk, i_rst_n, o_result_strobe, r_outstanding != '0, "result without a closed profile")
    `BSC_ASSERT_IMP(a_busy_only_when_full, i_clk, i_rst_n, o_busy, r_outstanding >= OUT_W'(bsc_pkg::QUEUE_DEPTH), "busy with free queue room")
    `BSC_ASSERT_IMP(a_zero_weight_result, i_clk, i_rst_n, o_result_strobe && o_zero_weight, o_centroid_position == '0, "zero weight with nonzero centroid")
    `BSC_ASSERT_NEXT(a_quiet_after_reset, i_clk, !i_rst_n, !o_result_strobe && !o_busy, "activity right after reset")

endmodule

bind background_subtracted_centroid bsc_checker #(
    .POSITION_BITS (POSITION_BITS)
) u_bsc_checker (.*);
